### hw/rtl/ppm_p6_stream_decoder_defines.svh
// ============================================================================
// ppm_p6_stream_decoder_defines.svh
// Assertion macros used by the PPM P6 parser controller (ppm_p6_ctrl).
// ============================================================================
`ifndef PPM_P6_STREAM_DECODER_DEFINES_SVH
`define PPM_P6_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PPM_P6_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppm_p6: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define PPM_P6_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppm_p6: next-cycle check failed");

`endif

### hw/rtl/ppm_p6_pkg.sv
// ============================================================================
// ppm_p6_pkg
// Types, widths and constants shared by the PPM P6 decoder modules.
// ============================================================================
package ppm_p6_pkg;

    localparam int DIM_W      = 12;     // width/height/column/row counters
    localparam int MAX_DIM    = 4095;
    localparam int MAX_FRAMES = 16;
    localparam int F_W        = 5;      // frame count 1..MAX_FRAMES
    localparam int FRAME_W    = 4;      // frame index
    localparam int SKIP_W     = 6;      // leftover bytes per row
    localparam int CNT_W      = $clog2(DIM_W + 1);

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_SIX  = 8'h36;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [DIM_W-1:0] MAXVAL_OK = DIM_W'(255);

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic       last;
        logic       acc_ld;
        logic       acc_add;
        logic       wid_ld;
        logic       hgt_ld;
        logic       div_start;
        logic       red_ld;
        logic       green_ld;
        logic       chan_wr;
        logic [1:0] chan_val;
        logic       pix_step;
        logic       skip_ld;
        logic       skip_dec;
        logic       row_clr;
        logic       row_inc;
        logic       row_begin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       busy;
        logic       add_ovf;
        logic       acc_255;
        logic [1:0] chan;
        logic       col_last;
        logic       frame_last;
        logic       row_last;
        logic       h_zero;
        logic       fw_zero;
        logic       skip_nz;
        logic       skip_end;
    } t_stat;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FRAME_W-1:0] frame;
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last;
    } t_result;

endpackage

### hw/rtl/ppm_p6_div.sv
// ============================================================================
// ppm_p6_div
// Restoring divider, one quotient bit per cycle: width / frame count.
// ============================================================================
module ppm_p6_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppm_p6_pkg::DIM_W-1:0]  i_dividend,
    input  logic [ppm_p6_pkg::F_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [ppm_p6_pkg::DIM_W-1:0]  o_quo,
    output logic [ppm_p6_pkg::F_W-1:0]    o_rem
);
    import ppm_p6_pkg::*;

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [F_W-1:0]     r_div;
    logic [DIM_W-1:0]   r_quo;
    logic [F_W-1:0]     r_rem;

    logic [F_W:0]       trial;
    logic               ge;
    logic [DIM_W-1:0]   n_quo;
    logic [F_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIM_W-1]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? F_W'(trial - {1'b0, r_div}) : trial[F_W-1:0];
        n_quo = {r_quo[DIM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == CNT_W'(1));
    assign o_quo  = n_quo;
    assign o_rem  = n_rem;

endmodule

### hw/rtl/ppm_p6_ctrl.sv
// ============================================================================
// ppm_p6_ctrl
// Parser state machine: header syntax, pixel and row sequencing.
// ============================================================================
`include "ppm_p6_stream_decoder_defines.svh"

module ppm_p6_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_sof,
    input  logic                 i_out_free,
    input  ppm_p6_pkg::t_stat    i_stat,
    output ppm_p6_pkg::t_cmd     o_cmd,
    output logic                 o_in_ready
);
    import ppm_p6_pkg::*;

    localparam logic [3:0] PH_P      = 4'd0;
    localparam logic [3:0] PH_6      = 4'd1;
    localparam logic [3:0] PH_SEP    = 4'd2;
    localparam logic [3:0] PH_SKIP_W = 4'd3;
    localparam logic [3:0] PH_NUM_W  = 4'd4;
    localparam logic [3:0] PH_SKIP_H = 4'd5;
    localparam logic [3:0] PH_NUM_H  = 4'd6;
    localparam logic [3:0] PH_SKIP_M = 4'd7;
    localparam logic [3:0] PH_NUM_M  = 4'd8;
    localparam logic [3:0] PH_PIXEL  = 4'd9;
    localparam logic [3:0] PH_RSKIP  = 4'd10;
    localparam logic [3:0] PH_IDLE   = 4'd11;
    localparam logic [3:0] PH_DIV    = 4'd12;
    localparam logic [3:0] PH_HDR    = 4'd13;

    logic [3:0] r_phase, n_phase;
    logic       r_in_comment, n_in_comment;

    logic [3:0] ph;
    logic       com;
    logic       pass;
    logic       is_ws;
    logic       is_digit;
    logic [3:0] tail_phase;   // begin_row outcome when rows remain
    logic       tail_skip;

    always_comb begin
        is_ws    = (i_byte inside {8'd32, [8'd9:8'd13]});
        is_digit = (i_byte inside {[8'h30:8'h39]});
        tail_skip  = i_stat.fw_zero && i_stat.skip_nz;
        tail_phase = !i_stat.fw_zero ? PH_PIXEL : (i_stat.skip_nz ? PH_RSKIP : PH_IDLE);
    end

    always_comb begin
        o_cmd        = '0;
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        ph           = i_sof ? PH_P : r_phase;
        com          = i_sof ? 1'b0 : r_in_comment;
        pass         = 1'b1;

        if (i_accept) begin
            if (i_sof) begin
                n_in_comment = 1'b0;
            end
            // comments count as whitespace between header fields
            if (ph inside {[PH_SEP:PH_NUM_M]}) begin
                if (com) begin
                    if (i_byte != CH_LF) begin
                        pass = 1'b0;
                    end else begin
                        n_in_comment = 1'b0;
                    end
                end else if (i_byte == CH_HASH) begin
                    n_in_comment = 1'b1;
                    pass = 1'b0;
                end
            end

            if (pass) begin
                n_phase = ph;
                case (ph)
                    PH_P: begin
                        n_phase = (i_byte == CH_P) ? PH_6 : PH_IDLE;
                        o_cmd.emit = (i_byte != CH_P);
                    end
                    PH_6: begin
                        n_phase = (i_byte == CH_SIX) ? PH_SEP : PH_IDLE;
                        o_cmd.emit = (i_byte != CH_SIX);
                    end
                    PH_SEP: begin
                        n_phase = is_ws ? PH_SKIP_W : PH_IDLE;
                        o_cmd.emit = !is_ws;
                    end
                    PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
                        if (is_digit) begin
                            o_cmd.acc_ld = 1'b1;
                            n_phase = ph + 4'd1;
                        end else if (!is_ws) begin
                            o_cmd.emit = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
                        if (is_digit) begin
                            if (i_stat.add_ovf) begin
                                o_cmd.emit = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                o_cmd.acc_add = 1'b1;
                            end
                        end else if (!is_ws) begin
                            o_cmd.emit = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (ph == PH_NUM_W) begin
                            o_cmd.wid_ld = 1'b1;
                            n_phase = PH_SKIP_H;
                        end else if (ph == PH_NUM_H) begin
                            o_cmd.hgt_ld = 1'b1;
                            n_phase = PH_SKIP_M;
                        end else if (!i_stat.acc_255) begin
                            o_cmd.emit = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_phase = PH_DIV;
                        end
                    end
                    PH_PIXEL: begin
                        if (i_stat.chan == 2'd1) begin
                            o_cmd.green_ld = 1'b1;
                            o_cmd.chan_wr  = 1'b1;
                            o_cmd.chan_val = 2'd2;
                        end else if (i_stat.chan != 2'd2) begin
                            o_cmd.red_ld   = 1'b1;
                            o_cmd.chan_wr  = 1'b1;
                            o_cmd.chan_val = 2'd1;
                        end else begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.kind     = KIND_PIXEL;
                            o_cmd.chan_wr  = 1'b1;
                            o_cmd.chan_val = 2'd0;
                            o_cmd.pix_step = 1'b1;
                            if (i_stat.col_last && i_stat.frame_last) begin
                                if (i_stat.row_last) begin
                                    o_cmd.last = 1'b1;
                                    n_phase = PH_IDLE;
                                end else if (i_stat.skip_nz) begin
                                    o_cmd.skip_ld = 1'b1;
                                    n_phase = PH_RSKIP;
                                end else begin
                                    o_cmd.row_inc   = 1'b1;
                                    o_cmd.row_begin = 1'b1;
                                end
                            end
                        end
                    end
                    PH_RSKIP: begin
                        o_cmd.skip_dec = 1'b1;
                        if (i_stat.skip_end) begin
                            o_cmd.row_inc   = 1'b1;
                            o_cmd.row_begin = 1'b1;
                            if (i_stat.row_last) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = tail_phase;
                                o_cmd.skip_ld = tail_skip;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (o_cmd.emit && (o_cmd.kind != KIND_PIXEL || ph != PH_PIXEL)) begin
                    // every emit outside the pixel phase is a format error
                    o_cmd.kind   = KIND_ERROR;
                    n_in_comment = 1'b0;
                end
            end
        end else if (r_phase == PH_DIV) begin
            if (!i_stat.busy) begin
                n_phase = PH_HDR;
            end
        end else if (r_phase == PH_HDR && i_out_free) begin
            o_cmd.emit      = 1'b1;
            o_cmd.kind      = KIND_HEADER;
            o_cmd.row_clr   = 1'b1;
            o_cmd.row_begin = 1'b1;
            if (i_stat.h_zero) begin
                n_phase = PH_IDLE;
            end else begin
                n_phase = tail_phase;
                o_cmd.skip_ld = tail_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_P;
            r_in_comment <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
        end
    end

    assign o_in_ready = !(r_phase == PH_DIV || r_phase == PH_HDR) && !i_stat.busy;

    `PPM_P6_ASSERT_NOW(a_emit_source, i_clk, i_rst_n, (!i_accept && r_phase != PH_HDR), (!o_cmd.emit))
    `PPM_P6_ASSERT_NEXT(a_div_follows, i_clk, i_rst_n, o_cmd.div_start, (r_phase == PH_DIV && i_stat.busy))
    `PPM_P6_ASSERT_NEXT(a_last_idles, i_clk, i_rst_n, (o_cmd.emit && o_cmd.last), (r_phase == PH_IDLE))

endmodule

### hw/rtl/ppm_p6_dp.sv
// ============================================================================
// ppm_p6_dp
// Datapath: number accumulator, image geometry, pixel counters, divider.
// ============================================================================
module ppm_p6_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppm_p6_pkg::t_cmd              i_cmd,
    input  logic [7:0]                    i_byte,
    input  logic [ppm_p6_pkg::F_W-1:0]    i_f_now,
    input  logic                          i_cfg_start,
    input  logic [ppm_p6_pkg::F_W-1:0]    i_div_f,
    output ppm_p6_pkg::t_stat             o_stat,
    output ppm_p6_pkg::t_result           o_result
);
    import ppm_p6_pkg::*;

    logic [DIM_W-1:0]   r_acc;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [DIM_W-1:0]   r_fw;
    logic [F_W-1:0]     r_rem;
    logic [DIM_W-1:0]   r_col;
    logic [DIM_W-1:0]   r_row;
    logic [FRAME_W-1:0] r_frame;
    logic [1:0]         r_chan;
    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [SKIP_W-1:0]  r_skip;
    logic               r_hdr_div;

    logic [3:0]         digit;
    logic [DIM_W+3:0]   acc_sum;
    logic [SKIP_W-1:0]  row_skip;
    logic               div_busy;
    logic               div_done;
    logic [DIM_W-1:0]   div_quo;
    logic [F_W-1:0]     div_rem;

    always_comb begin
        digit    = 4'(i_byte - CH_ZERO);
        acc_sum  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (DIM_W+4)'(digit);
        row_skip = ({1'b0, r_rem} << 1) + SKIP_W'(r_rem);
    end

    ppm_p6_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start || i_cfg_start),
        .i_dividend (r_width),
        .i_divisor  (i_div_f),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_div <= 1'b0;
        end else if (i_cmd.div_start || i_cfg_start) begin
            r_hdr_div <= i_cmd.div_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_ld) begin
            r_acc <= DIM_W'(digit);
        end else if (i_cmd.acc_add) begin
            r_acc <= acc_sum[DIM_W-1:0];
        end
        if (i_cmd.wid_ld) begin
            r_width <= r_acc;
        end
        if (i_cmd.hgt_ld) begin
            r_height <= r_acc;
        end
        if (div_done) begin
            r_rem <= div_rem;
            if (r_hdr_div) begin
                r_fw <= div_quo;
            end
        end
        if (i_cmd.red_ld) begin
            r_red <= i_byte;
        end
        if (i_cmd.green_ld) begin
            r_green <= i_byte;
        end

        if (i_cmd.pix_step) begin
            if (o_stat.col_last) begin
                r_col <= '0;
                if (!o_stat.frame_last) begin
                    r_frame <= r_frame + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (i_cmd.chan_wr) begin
            r_chan <= i_cmd.chan_val;
        end
        if (i_cmd.row_begin) begin
            r_col   <= '0;
            r_frame <= '0;
            r_chan  <= 2'd0;
        end

        if (i_cmd.row_clr) begin
            r_row <= '0;
        end else if (i_cmd.row_inc) begin
            r_row <= r_row + 1'b1;
        end

        if (i_cmd.skip_ld) begin
            r_skip <= row_skip;
        end else if (i_cmd.skip_dec && r_skip != '0) begin
            r_skip <= r_skip - 1'b1;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.busy       = div_busy;
        o_stat.add_ovf    = (acc_sum > (DIM_W+4)'(MAX_DIM));
        o_stat.acc_255    = (r_acc == MAXVAL_OK);
        o_stat.chan       = r_chan;
        o_stat.col_last   = ({1'b0, r_col} + 1'b1) >= {1'b0, r_fw};
        o_stat.frame_last = ({1'b0, r_frame} + 1'b1) >= i_f_now;
        o_stat.row_last   = ({1'b0, r_row} + 1'b1) >= {1'b0, r_height};
        o_stat.h_zero     = (r_height == '0);
        o_stat.fw_zero    = (r_fw == '0);
        o_stat.skip_nz    = (r_rem != '0);
        o_stat.skip_end   = (r_skip <= SKIP_W'(1));
    end

    always_comb begin
        o_result      = '0;
        o_result.kind = i_cmd.kind;
        case (i_cmd.kind)
            KIND_PIXEL: begin
                o_result.frame = r_frame;
                o_result.col   = r_col;
                o_result.row   = r_row;
                o_result.red   = r_red;
                o_result.green = r_green;
                o_result.blue  = i_byte;
                o_result.last  = i_cmd.last;
            end
            KIND_HEADER: begin
                o_result.col = r_fw;
                o_result.row = r_height;
            end
            default: begin
            end
        endcase
    end

endmodule

### hw/rtl/ppm_p6_stream_decoder.sv
// ============================================================================
// ppm_p6_stream_decoder
// Binary PPM (P6) byte-stream parser that splits image rows into frames.
// ============================================================================
// Bytes of a P6 file enter on the s_axis side, one item per byte, with tuser
// set on the first byte of a file (this restarts the parser). The header
// "P6", width, height and maxval (must be 255) is checked; whitespace and
// '#' comments separate the fields. A syntax error or a value above 4095
// gives one error item and input is then dropped until the next tuser.
// Once the header is done the block computes the frame width
// (width / frames_across) on a bit-serial divider, which holds s_axis_tready
// low through its 12 divide steps and a handover step, then sends one
// header item (tdata col = frame width, row = height). After that every RGB
// byte triple inside a frame gives one pixel item; tlast marks the final
// pixel of the image, and the leftover pixels of each row are consumed
// without output. Apart from that divide and the header item, one byte
// is taken per cycle. Results sit in an output register; a new byte
// is taken only while that register is empty or being drained, so a result
// the receiver does not take holds off the input.
// frames_across (cfg channel; 0 acts as 1, above 16 as 16) is written by the
// user only while the block has no work pending; the block does not enforce
// this. Each write reruns the row-remainder divide, holding off input and cfg.
// ============================================================================
module ppm_p6_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] start_of_file
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [3:0] frame, [15:4] col, [27:16] row,
                                        // [35:28] red, [43:36] green,
                                        // [51:44] blue, [55:52] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last pixel of the image
    // configuration: frames_across
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import ppm_p6_pkg::*;

    t_cmd           cmd;
    t_stat          stat;
    t_result        result;

    logic [F_W-1:0] r_frames;       // clamped frames_across
    t_result        r_out;
    logic           r_out_valid;

    logic           out_free;
    logic           in_ready;
    logic           in_accept;
    logic           cfg_accept;
    logic [F_W-1:0] cfg_clamped;
    logic [F_W-1:0] div_f;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = F_W'(1);
        end else if (i_cfg_data > F_W'(MAX_FRAMES)) begin
            cfg_clamped = F_W'(MAX_FRAMES);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = in_ready && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = !stat.busy;
    assign cfg_accept    = i_cfg_valid && o_cfg_ready;
    // a config write reruns the remainder with the new count right away
    assign div_f         = cfg_accept ? cfg_clamped : r_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= F_W'(1);
        end else if (cfg_accept) begin
            r_frames <= cfg_clamped;
        end
    end

    ppm_p6_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_byte     (s_axis_tdata),
        .i_sof      (s_axis_tuser),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ppm_p6_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_byte      (s_axis_tdata),
        .i_f_now     (r_frames),
        .i_cfg_start (cfg_accept),
        .i_div_f     (div_f),
        .o_stat      (stat),
        .o_result    (result)
    );

    // output register: emit only happens when out_free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'b0, r_out.blue, r_out.green, r_out.red,
                            r_out.row, r_out.col, r_out.frame};

endmodule
